>>> design/triangle_edge_rasterizer_defines.svh
// Assertion macros shared by the rasterizer RTL.
// Both forms expect a clock named clk and an active-low reset named arst_n in scope.
`ifndef TRIANGLE_EDGE_RASTERIZER_DEFINES_SVH
`define TRIANGLE_EDGE_RASTERIZER_DEFINES_SVH

`ifndef SYNTHESIS

// Checked only while the block is out of reset.
`define TER_ASSERT(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("rasterizer assertion failed");

// Checked at every clock edge, reset included.
`define TER_ASSERT_ALWAYS(name, prop) \
	name: assert property (@(posedge clk) prop) \
		else $error("rasterizer assertion failed");

`else

`define TER_ASSERT(name, prop)
`define TER_ASSERT_ALWAYS(name, prop)

`endif

`endif

>>> design/ter_pkg.sv
package ter_pkg;

	localparam int TILE_WIDTH    = 8;
	localparam int TILE_HEIGHT   = 8;
	localparam int FRACTION_BITS = 4;

	// At most this many row results per tile and mask bits per row.
	localparam int MAX_ROWS = 8;
	localparam int MAX_COLS = 8;

	localparam int COORD_W    = 16;
	localparam int TILE_IDX_W = 9;
	localparam int SCREEN_W   = 13;
	localparam int POS_W      = 12;

	localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RESET  = 13'd640;
	localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RESET = 13'd480;

	typedef enum logic [0:0] {
		REG_SCREEN_WIDTH  = 1'b0,
		REG_SCREEN_HEIGHT = 1'b1
	} cfg_reg_t;

	// Corner order is a, b, c. Edge k runs from EDGE_FIRST[k] to EDGE_SECOND[k].
	localparam int EDGE_FIRST  [3] = '{1, 2, 0};
	localparam int EDGE_SECOND [3] = '{2, 0, 1};

	typedef struct packed {
		logic signed [COORD_W-1:0] corner_a_x;
		logic signed [COORD_W-1:0] corner_a_y;
		logic signed [COORD_W-1:0] corner_b_x;
		logic signed [COORD_W-1:0] corner_b_y;
		logic signed [COORD_W-1:0] corner_c_x;
		logic signed [COORD_W-1:0] corner_c_y;
		logic [TILE_IDX_W-1:0]     tile_column;
		logic [TILE_IDX_W-1:0]     tile_row;
	} in_item_t;

	typedef struct packed {
		logic [POS_W-1:0]    pixel_row;
		logic [POS_W-1:0]    first_column;
		logic [MAX_COLS-1:0] coverage_mask;
		logic                last_row;
	} out_row_t;

endpackage

>>> design/ter_setup.sv
// Per-triangle setup: edge deltas, bounding box, then the edge values at the
// tile origin and their per-pixel steps. Four register stages.
module ter_setup #(
	parameter int TILE_WIDTH    = ter_pkg::TILE_WIDTH,
	parameter int TILE_HEIGHT   = ter_pkg::TILE_HEIGHT,
	parameter int FRACTION_BITS = ter_pkg::FRACTION_BITS,
	localparam int XW  = ter_pkg::TILE_IDX_W + $clog2(TILE_WIDTH),
	localparam int YW  = ter_pkg::TILE_IDX_W + $clog2(TILE_HEIGHT),
	localparam int PW  = ((XW > YW) ? XW : YW) + FRACTION_BITS,
	localparam int DW  = ((PW + 1 > ter_pkg::COORD_W) ? PW + 1 : ter_pkg::COORD_W) + 1,
	localparam int PRW = ter_pkg::COORD_W + 1 + DW,
	localparam int EW  = PRW + 1,
	localparam int BBW = ter_pkg::COORD_W + 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  ter_pkg::in_item_t   item,
	output logic                setup_valid,
	output logic signed [EW-1:0] e0 [3],
	output logic signed [EW-1:0] dx [3],
	output logic signed [EW-1:0] dy [3],
	output logic signed [BBW-1:0] xmin,
	output logic signed [BBW-1:0] xmax,
	output logic signed [BBW-1:0] ymin,
	output logic signed [BBW-1:0] ymax,
	output logic [XW-1:0]       tx,
	output logic [YW-1:0]       ty
);

	localparam int CW   = ter_pkg::COORD_W;
	localparam int HALF = (1 << FRACTION_BITS) >> 1;

	// Stage 1: captured item.
	logic              valid_s1;
	ter_pkg::in_item_t item_s1;

	// Stage 2: differences and bounding box.
	logic                 valid_s2;
	logic signed [CW:0]   ex_s2 [3];
	logic signed [CW:0]   ey_s2 [3];
	logic signed [DW-1:0] rx_s2 [3];
	logic signed [DW-1:0] ry_s2 [3];
	logic signed [BBW-1:0] bbox_s2 [4];
	logic [XW-1:0]        tx_s2;
	logic [YW-1:0]        ty_s2;

	// Stage 3: products.
	logic                  valid_s3;
	logic signed [PRW-1:0] prod_y_s3 [3];
	logic signed [PRW-1:0] prod_x_s3 [3];
	logic signed [CW:0]    ex_s3 [3];
	logic signed [CW:0]    ey_s3 [3];
	logic signed [BBW-1:0] bbox_s3 [4];
	logic [XW-1:0]         tx_s3;
	logic [YW-1:0]         ty_s3;

	// Stage 4: origin edge values and steps.
	logic                  valid_s4;
	logic signed [EW-1:0]  e0_s4 [3];
	logic signed [EW-1:0]  dx_s4 [3];
	logic signed [EW-1:0]  dy_s4 [3];
	logic signed [BBW-1:0] bbox_s4 [4];
	logic [XW-1:0]         tx_s4;
	logic [YW-1:0]         ty_s4;

	logic signed [CW-1:0]  cx_c [3];
	logic signed [CW-1:0]  cy_c [3];
	logic signed [CW-1:0]  min_x_c, max_x_c, min_y_c, max_y_c;
	logic [XW-1:0]         tx_c;
	logic [YW-1:0]         ty_c;
	logic [PW-1:0]         px0_c, py0_c;
	logic signed [CW:0]    ex_c [3];
	logic signed [CW:0]    ey_c [3];
	logic signed [DW-1:0]  rx_c [3];
	logic signed [DW-1:0]  ry_c [3];
	logic signed [BBW-1:0] bbox_c [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	always_comb begin
		cx_c[0] = item_s1.corner_a_x;
		cy_c[0] = item_s1.corner_a_y;
		cx_c[1] = item_s1.corner_b_x;
		cy_c[1] = item_s1.corner_b_y;
		cx_c[2] = item_s1.corner_c_x;
		cy_c[2] = item_s1.corner_c_y;

		min_x_c = cx_c[0];
		max_x_c = cx_c[0];
		min_y_c = cy_c[0];
		max_y_c = cy_c[0];
		for (int k = 1; k < 3; k++) begin
			if (cx_c[k] < min_x_c) min_x_c = cx_c[k];
			if (cx_c[k] > max_x_c) max_x_c = cx_c[k];
			if (cy_c[k] < min_y_c) min_y_c = cy_c[k];
			if (cy_c[k] > max_y_c) max_y_c = cy_c[k];
		end

		// Round half up to whole pixels: floor((v + half) / one).
		bbox_c[0] = (BBW'(min_x_c) + BBW'(HALF)) >>> FRACTION_BITS;
		bbox_c[1] = (BBW'(max_x_c) + BBW'(HALF)) >>> FRACTION_BITS;
		bbox_c[2] = (BBW'(min_y_c) + BBW'(HALF)) >>> FRACTION_BITS;
		bbox_c[3] = (BBW'(max_y_c) + BBW'(HALF)) >>> FRACTION_BITS;

		tx_c  = XW'(item_s1.tile_column * TILE_WIDTH);
		ty_c  = YW'(item_s1.tile_row * TILE_HEIGHT);
		px0_c = PW'(tx_c) << FRACTION_BITS;
		py0_c = PW'(ty_c) << FRACTION_BITS;

		for (int k = 0; k < 3; k++) begin
			ex_c[k] = (CW+1)'(cx_c[ter_pkg::EDGE_SECOND[k]]) -
				(CW+1)'(cx_c[ter_pkg::EDGE_FIRST[k]]);
			ey_c[k] = (CW+1)'(cy_c[ter_pkg::EDGE_SECOND[k]]) -
				(CW+1)'(cy_c[ter_pkg::EDGE_FIRST[k]]);
			rx_c[k] = $signed(DW'(px0_c)) - DW'(cx_c[ter_pkg::EDGE_FIRST[k]]);
			ry_c[k] = $signed(DW'(py0_c)) - DW'(cy_c[ter_pkg::EDGE_FIRST[k]]);
		end
	end

	always_ff @(posedge clk) begin
		ex_s2   <= ex_c;
		ey_s2   <= ey_c;
		rx_s2   <= rx_c;
		ry_s2   <= ry_c;
		bbox_s2 <= bbox_c;
		tx_s2   <= tx_c;
		ty_s2   <= ty_c;

		for (int k = 0; k < 3; k++) begin
			prod_y_s3[k] <= PRW'(ex_s2[k]) * PRW'(ry_s2[k]);
			prod_x_s3[k] <= PRW'(rx_s2[k]) * PRW'(ey_s2[k]);
		end
		ex_s3   <= ex_s2;
		ey_s3   <= ey_s2;
		bbox_s3 <= bbox_s2;
		tx_s3   <= tx_s2;
		ty_s3   <= ty_s2;

		// E = ex * (py - Py) - (px - Px) * ey, so one pixel right adds -ey * one
		// and one pixel down adds ex * one.
		for (int k = 0; k < 3; k++) begin
			e0_s4[k] <= EW'(prod_y_s3[k]) - EW'(prod_x_s3[k]);
			dx_s4[k] <= -(EW'(ey_s3[k]) <<< FRACTION_BITS);
			dy_s4[k] <= EW'(ex_s3[k]) <<< FRACTION_BITS;
		end
		bbox_s4 <= bbox_s3;
		tx_s4   <= tx_s3;
		ty_s4   <= ty_s3;
	end

	assign setup_valid = valid_s4;
	assign e0   = e0_s4;
	assign dx   = dx_s4;
	assign dy   = dy_s4;
	assign xmin = bbox_s4[0];
	assign xmax = bbox_s4[1];
	assign ymin = bbox_s4[2];
	assign ymax = bbox_s4[3];
	assign tx   = tx_s4;
	assign ty   = ty_s4;

endmodule

>>> design/triangle_edge_rasterizer.sv
// Edge-function triangle rasterizer for one tile per transaction.
// Input: pulse start with the triangle corners (signed fixed point) and the
// tile position on item; the item is taken at a clock edge where start is high
// and busy is low. busy stays high after each accepted item while a gap counter
// loaded with the last row index counts down to zero, so items are spaced one
// tile's worth of rows apart at the least, and an item can follow right away once
// busy drops while the previous tile is still in flight.
// Output: one row result per tile row, up to MAX_ROWS, top row first, each
// shown on row for one cycle with row_valid high; the rows of one tile come in
// consecutive cycles and the last one has last_row set. The first row passes
// through four setup stages, a row sequencer that steps the edge values down
// one row per cycle, a lane stage that evaluates all columns of the row at
// once, and the output register.
// Configuration: wr_en with wr_index and wr_data writes screen_width or
// screen_height in the same edge; write only while no tile is in flight.
// Reset clears the pipeline and loads a 640 by 480 screen. The receiver
// cannot stall, so nothing holds the pipeline back.
`include "triangle_edge_rasterizer_defines.svh"

module triangle_edge_rasterizer #(
	parameter int TILE_WIDTH    = ter_pkg::TILE_WIDTH,
	parameter int TILE_HEIGHT   = ter_pkg::TILE_HEIGHT,
	parameter int FRACTION_BITS = ter_pkg::FRACTION_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  ter_pkg::in_item_t             item,
	input  logic                          wr_en,
	input  ter_pkg::cfg_reg_t             wr_index,
	input  logic [ter_pkg::SCREEN_W-1:0]  wr_data,
	output logic                          row_valid,
	output ter_pkg::out_row_t             row
);

	localparam int XW  = ter_pkg::TILE_IDX_W + $clog2(TILE_WIDTH);
	localparam int YW  = ter_pkg::TILE_IDX_W + $clog2(TILE_HEIGHT);
	localparam int PW  = ((XW > YW) ? XW : YW) + FRACTION_BITS;
	localparam int DW  = ((PW + 1 > ter_pkg::COORD_W) ? PW + 1 : ter_pkg::COORD_W) + 1;
	localparam int PRW = ter_pkg::COORD_W + 1 + DW;
	localparam int EW  = PRW + 1;
	localparam int BBW = ter_pkg::COORD_W + 1;
	localparam int ROWS  = (TILE_HEIGHT < ter_pkg::MAX_ROWS) ? TILE_HEIGHT : ter_pkg::MAX_ROWS;
	localparam int COLS  = (TILE_WIDTH < ter_pkg::MAX_COLS) ? TILE_WIDTH : ter_pkg::MAX_COLS;
	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

	logic [ter_pkg::SCREEN_W-1:0] screen_width_q;
	logic [ter_pkg::SCREEN_W-1:0] screen_height_q;
	logic [ROW_W-1:0]             gap_q;
	logic                         accept;

	logic                  setup_valid;
	logic signed [EW-1:0]  e0 [3];
	logic signed [EW-1:0]  dx [3];
	logic signed [EW-1:0]  dy [3];
	logic signed [BBW-1:0] xmin, xmax, ymin, ymax;
	logic [XW-1:0]         tx;
	logic [YW-1:0]         ty;

	// Row sequencer.
	logic                  active_s5;
	logic [ROW_W-1:0]      row_s5;
	logic signed [EW-1:0]  e_row_s5 [3];
	logic signed [EW-1:0]  dx_s5 [3];
	logic signed [EW-1:0]  dy_s5 [3];
	logic signed [BBW-1:0] xmin_s5, xmax_s5, ymin_s5, ymax_s5;
	logic [XW-1:0]         tx_s5;
	logic [YW-1:0]         ty_s5;

	// Column lanes.
	logic                  valid_s6;
	logic signed [EW-1:0]  e_lane_s6 [COLS][3];
	logic [COLS-1:0]       col_ok_s6;
	logic                  row_ok_s6;
	logic [YW-1:0]         y_s6;
	logic [XW-1:0]         tx_s6;
	logic                  last_s6;

	// Output register.
	logic                  valid_s7;
	ter_pkg::out_row_t     row_s7;

	logic [YW-1:0]         y_c;
	logic signed [DW-1:0]  ys_c;
	logic                  row_ok_c;
	logic [COLS-1:0]       col_ok_c;
	logic [XW-1:0]         x_c;
	logic signed [DW-1:0]  xs_c;
	logic [ter_pkg::MAX_COLS-1:0] mask_c;
	logic                  inside_c;

	assign accept = start && !busy;
	assign busy   = (gap_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= ter_pkg::SCREEN_WIDTH_RESET;
			screen_height_q <= ter_pkg::SCREEN_HEIGHT_RESET;
		end else if (wr_en) begin
			case (wr_index)
				ter_pkg::REG_SCREEN_WIDTH: begin
					screen_width_q <= wr_data;
				end
				ter_pkg::REG_SCREEN_HEIGHT: begin
					screen_height_q <= wr_data;
				end
				default: begin
				end
			endcase
		end
	end

	// Items are spaced one tile's worth of rows apart at the least, so each one
	// reaches the sequencer no earlier than the previous tile leaves it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= '0;
		end else if (accept) begin
			gap_q <= ROW_LAST;
		end else if (gap_q != '0) begin
			gap_q <= gap_q - 1'b1;
		end
	end

	ter_setup #(
		.TILE_WIDTH   (TILE_WIDTH),
		.TILE_HEIGHT  (TILE_HEIGHT),
		.FRACTION_BITS(FRACTION_BITS)
	) u_setup (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.item       (item),
		.setup_valid(setup_valid),
		.e0         (e0),
		.dx         (dx),
		.dy         (dy),
		.xmin       (xmin),
		.xmax       (xmax),
		.ymin       (ymin),
		.ymax       (ymax),
		.tx         (tx),
		.ty         (ty)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_s5 <= 1'b0;
			row_s5    <= '0;
			valid_s6  <= 1'b0;
			valid_s7  <= 1'b0;
		end else begin
			active_s5 <= setup_valid || (active_s5 && (row_s5 != ROW_LAST));
			if (setup_valid) begin
				row_s5 <= '0;
			end else if (active_s5) begin
				row_s5 <= row_s5 + 1'b1;
			end
			valid_s6 <= active_s5;
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (setup_valid) begin
			e_row_s5 <= e0;
			dx_s5    <= dx;
			dy_s5    <= dy;
			xmin_s5  <= xmin;
			xmax_s5  <= xmax;
			ymin_s5  <= ymin;
			ymax_s5  <= ymax;
			tx_s5    <= tx;
			ty_s5    <= ty;
		end else if (active_s5) begin
			for (int k = 0; k < 3; k++) begin
				e_row_s5[k] <= e_row_s5[k] + dy_s5[k];
			end
		end
	end

	always_comb begin
		y_c      = ty_s5 + YW'(row_s5);
		ys_c     = $signed(DW'(y_c));
		row_ok_c = (ys_c >= DW'(ymin_s5)) && (ys_c <= DW'(ymax_s5)) &&
			(ys_c < $signed(DW'(screen_height_q)));
		col_ok_c = '0;
		x_c      = '0;
		xs_c     = '0;
		for (int i = 0; i < COLS; i++) begin
			x_c  = tx_s5 + XW'(i);
			xs_c = $signed(DW'(x_c));
			col_ok_c[i] = (xs_c >= DW'(xmin_s5)) && (xs_c <= DW'(xmax_s5)) &&
				(xs_c < $signed(DW'(screen_width_q)));
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < COLS; i++) begin
			for (int k = 0; k < 3; k++) begin
				e_lane_s6[i][k] <= e_row_s5[k] + dx_s5[k] * $signed(EW'(i));
			end
		end
		col_ok_s6 <= col_ok_c;
		row_ok_s6 <= row_ok_c;
		y_s6      <= y_c;
		tx_s6     <= tx_s5;
		last_s6   <= (row_s5 == ROW_LAST);
	end

	always_comb begin
		mask_c   = '0;
		inside_c = 1'b0;
		for (int i = 0; i < COLS; i++) begin
			inside_c = (e_lane_s6[i][0] > 0) && (e_lane_s6[i][1] > 0) &&
				(e_lane_s6[i][2] > 0);
			mask_c[i] = row_ok_s6 && col_ok_s6[i] && inside_c;
		end
	end

	always_ff @(posedge clk) begin
		row_s7.pixel_row     <= ter_pkg::POS_W'(y_s6);
		row_s7.first_column  <= ter_pkg::POS_W'(tx_s6);
		row_s7.coverage_mask <= mask_c;
		row_s7.last_row      <= last_s6;
	end

	assign row_valid = valid_s7;
	assign row       = row_s7;

	// A tile's rows leave without gaps until its last row.
	`TER_ASSERT(a_rows_contiguous, row_valid && !row.last_row |=> row_valid)
	// Every accepted item shows its first row after the fixed latency.
	`TER_ASSERT(a_fixed_latency, accept |-> ##7 row_valid)
	// A new setup only lands when the sequencer is free or on its last row.
	`TER_ASSERT(a_sequencer_free, setup_valid |-> !active_s5 || (row_s5 == ROW_LAST))
	// Reset holds the result strobe low.
	`TER_ASSERT_ALWAYS(a_quiet_in_reset, !arst_n |=> !row_valid)

endmodule
